[hdl/grs_pkg.sv]
// Shared types, constants and the control-store program of the grid reachability search core.
package grs_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ROW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COL   = 3'd5;

    // Register field widths and reset values.
    localparam int DIM_W   = 7;
    localparam int COORD_W = 6;
    localparam logic [DIM_W-1:0]   GRID_DIM_RST = 7'd64;
    localparam logic [COORD_W-1:0] COORD_RST    = 6'd0;

    // Stream data widths.
    localparam int TDATA_W = 8;

    // Cell memory entry: bit 0 open floor, bit 1 visited.
    localparam int CELL_W   = 2;
    localparam int OPEN_BIT = 0;
    localparam int SEEN_BIT = 1;

    // Datapath operation selected by a control word.
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_START,
        OP_MARK_RD,
        OP_MARK_WR,
        OP_POP,
        OP_POP_TAKE,
        OP_NB_RD,
        OP_NB_CHK,
        OP_DONE,
        OP_NOP
    } grs_op_t;

    // Neighbor direction, in push order.
    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } grs_dir_t;

    // Jump condition.
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_LAST_IN,
        C_HIT,
        C_NB_SKIP,
        C_EMPTY,
        C_OUT_FREE
    } grs_cond_t;

    typedef logic [3:0] grs_pc_t;

    localparam grs_pc_t PC_IDLE     = 4'd0;
    localparam grs_pc_t PC_START    = 4'd1;
    localparam grs_pc_t PC_MARK_RD  = 4'd2;
    localparam grs_pc_t PC_MARK_WR  = 4'd3;
    localparam grs_pc_t PC_POP      = 4'd4;
    localparam grs_pc_t PC_POP_TAKE = 4'd5;
    localparam grs_pc_t PC_NB_R_RD  = 4'd6;
    localparam grs_pc_t PC_NB_R_CK  = 4'd7;
    localparam grs_pc_t PC_NB_D_RD  = 4'd8;
    localparam grs_pc_t PC_NB_D_CK  = 4'd9;
    localparam grs_pc_t PC_NB_L_RD  = 4'd10;
    localparam grs_pc_t PC_NB_L_CK  = 4'd11;
    localparam grs_pc_t PC_NB_U_RD  = 4'd12;
    localparam grs_pc_t PC_NB_U_CK  = 4'd13;
    localparam grs_pc_t PC_DONE     = 4'd14;

    // One control word. On a taken jump the step goes to target; otherwise
    // it holds when hold is set, else advances by one.
    typedef struct packed {
        grs_op_t   op;
        grs_dir_t  dir;
        grs_cond_t cond;
        logic      hold;
        grs_pc_t   target;
    } grs_uword_t;

    function automatic grs_uword_t grs_uw(input grs_op_t op, input grs_dir_t dir,
                                          input grs_cond_t cond, input logic hold,
                                          input grs_pc_t target);
        grs_uword_t w;
        w.op     = op;
        w.dir    = dir;
        w.cond   = cond;
        w.hold   = hold;
        w.target = target;
        return w;
    endfunction

    // Control store.
    function automatic grs_uword_t grs_ucode(input grs_pc_t pc);
        grs_uword_t w;
        unique case (pc)
            PC_IDLE:     w = grs_uw(OP_LOAD,     DIR_RIGHT, C_LAST_IN,  1'b1, PC_START);
            PC_START:    w = grs_uw(OP_START,    DIR_RIGHT, C_HIT,      1'b0, PC_DONE);
            PC_MARK_RD:  w = grs_uw(OP_MARK_RD,  DIR_RIGHT, C_NONE,     1'b0, PC_IDLE);
            PC_MARK_WR:  w = grs_uw(OP_MARK_WR,  DIR_RIGHT, C_ALWAYS,   1'b0, PC_NB_R_RD);
            PC_POP:      w = grs_uw(OP_POP,      DIR_RIGHT, C_EMPTY,    1'b0, PC_DONE);
            PC_POP_TAKE: w = grs_uw(OP_POP_TAKE, DIR_RIGHT, C_HIT,      1'b0, PC_DONE);
            PC_NB_R_RD:  w = grs_uw(OP_NB_RD,    DIR_RIGHT, C_NB_SKIP,  1'b0, PC_NB_D_RD);
            PC_NB_R_CK:  w = grs_uw(OP_NB_CHK,   DIR_RIGHT, C_NONE,     1'b0, PC_IDLE);
            PC_NB_D_RD:  w = grs_uw(OP_NB_RD,    DIR_DOWN,  C_NB_SKIP,  1'b0, PC_NB_L_RD);
            PC_NB_D_CK:  w = grs_uw(OP_NB_CHK,   DIR_DOWN,  C_NONE,     1'b0, PC_IDLE);
            PC_NB_L_RD:  w = grs_uw(OP_NB_RD,    DIR_LEFT,  C_NB_SKIP,  1'b0, PC_NB_U_RD);
            PC_NB_L_CK:  w = grs_uw(OP_NB_CHK,   DIR_LEFT,  C_NONE,     1'b0, PC_IDLE);
            PC_NB_U_RD:  w = grs_uw(OP_NB_RD,    DIR_UP,    C_NB_SKIP,  1'b0, PC_POP);
            PC_NB_U_CK:  w = grs_uw(OP_NB_CHK,   DIR_UP,    C_ALWAYS,   1'b0, PC_POP);
            PC_DONE:     w = grs_uw(OP_DONE,     DIR_RIGHT, C_OUT_FREE, 1'b1, PC_IDLE);
            default:     w = grs_uw(OP_NOP,      DIR_RIGHT, C_ALWAYS,   1'b0, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

[hdl/grs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module grs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/grid_reachability_search_core.sv]
// Top level of the grid reachability search core: maze loader, control store sequencer, datapath.
//
//  Channel | Dir | Handshake         | Payload
//  --------+-----+-------------------+-------------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata[0] cell_open, [7:1] zero; s_tlast last_cell
//  m_      | out | m_tvalid/m_tready | m_tdata[0] path_found, [7:1] zero
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index register number, cfg_data write value
//
//  Loading takes one cell per cycle. After the cell with s_tlast the search runs: a
//  start step, a mark read and a mark write seed the start cell, and its neighbor scan
//  follows; each popped cell takes a pop and a take step, each neighbor a read step, and
//  each in-grid loaded neighbor also a check step. A final empty pop ends the scan and a
//  done step posts the result. The sequence is set by the control store, which issues at
//  most one cell memory access per step.
//  rst_n is asynchronous; reset sets the registers to their defaults, empties the stack
//  and the load count. No memory clearing pass is needed. s_tready is low during the
//  search and while a finished result waits on an earlier one stalled on the m_ channel.
module grid_reachability_search_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Maze cells
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [grs_pkg::TDATA_W-1:0]    s_tdata,   // [0] cell_open, [7:1] unused
    input  logic                           s_tlast,   // last_cell
    // Search result
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [grs_pkg::TDATA_W-1:0]    m_tdata,   // [0] path_found, [7:1] zero
    // Register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [grs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grs_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Widths derived from the grid bounds.
    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int RB  = $clog2(MAX_ROWS);          // row coordinate
    localparam int CB  = $clog2(MAX_COLS);          // column coordinate
    localparam int RN  = $clog2(MAX_ROWS + 1);      // row count
    localparam int CN  = $clog2(MAX_COLS + 1);      // column count
    localparam int AW  = $clog2(CELL_CAP);          // cell / stack address
    localparam int LW  = $clog2(CELL_CAP + 1);      // load and stack counts
    localparam int PW  = RN + CN;                   // product width
    localparam int SW  = RB + CB;                   // stack entry {row, col}
    localparam int XR  = (RN > grs_pkg::DIM_W) ? RN : grs_pkg::DIM_W;
    localparam int XC  = (CN > grs_pkg::DIM_W) ? CN : grs_pkg::DIM_W;
    localparam int ER  = (RB > grs_pkg::COORD_W) ? RB : grs_pkg::COORD_W;
    localparam int EC  = (CB > grs_pkg::COORD_W) ? CB : grs_pkg::COORD_W;

    // Configuration registers
    logic [grs_pkg::DIM_W-1:0]   grid_rows_reg, grid_cols_reg;
    logic [grs_pkg::COORD_W-1:0] start_row_reg, start_col_reg;
    logic [grs_pkg::COORD_W-1:0] end_row_reg, end_col_reg;

    // Sequencer and control state
    grs_pkg::grs_pc_t   pc_reg, pc_next;
    grs_pkg::grs_uword_t uw;
    logic               jump;
    logic [LW-1:0]      load_pos_reg, load_pos_next;
    logic [LW-1:0]      stack_cnt_reg, stack_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;

    // Datapath payload registers
    logic [RB-1:0]      cur_r_reg, cur_r_next;
    logic [CB-1:0]      cur_c_reg, cur_c_next;
    logic [AW-1:0]      lin_reg, lin_next;
    logic [RB-1:0]      nb_r_reg, nb_r_next;
    logic [CB-1:0]      nb_c_reg, nb_c_next;
    logic [AW-1:0]      nb_addr_reg, nb_addr_next;
    logic               path_reg, path_next;

    // Combinational datapath
    logic [RN-1:0]      rows_c;
    logic [CN-1:0]      cols_c;
    logic [PW-1:0]      cap_w;
    logic               in_acc;
    logic               load_wr;
    logic               start_off;
    logic [RB-1:0]      src_r;
    logic [CB-1:0]      src_c;
    logic               coord_match;
    logic               hit;
    logic               nb_in_grid;
    logic               nb_ok;
    logic [LW-1:0]      nb_addr_w;
    logic [RB-1:0]      nb_r_w;
    logic [CB-1:0]      nb_c_w;
    logic               push;
    logic               stack_room;

    // Memory ports
    logic                       cell_we, cell_re;
    logic [AW-1:0]              cell_waddr, cell_raddr;
    logic [grs_pkg::CELL_W-1:0] cell_wdata, cell_rdata;
    logic                       stk_we, stk_re;
    logic [AW-1:0]              stk_waddr, stk_raddr;
    logic [SW-1:0]              stk_wdata, stk_rdata;

    assign uw        = grs_pkg::grs_ucode(pc_reg);
    assign cfg_ready = 1'b1;
    assign s_tready  = (uw.op == grs_pkg::OP_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(grs_pkg::TDATA_W-1){1'b0}}, path_reg};

    // Grid size as used: zero acts as one, anything above the bound as the bound.
    always_comb
    begin
        if (grid_rows_reg == '0)
        begin
            rows_c = RN'(1);
        end
        else if (XR'(grid_rows_reg) > XR'(MAX_ROWS))
        begin
            rows_c = RN'(MAX_ROWS);
        end
        else
        begin
            rows_c = RN'(grid_rows_reg);
        end

        if (grid_cols_reg == '0)
        begin
            cols_c = CN'(1);
        end
        else if (XC'(grid_cols_reg) > XC'(MAX_COLS))
        begin
            cols_c = CN'(MAX_COLS);
        end
        else
        begin
            cols_c = CN'(grid_cols_reg);
        end
    end

    assign cap_w   = PW'(rows_c) * PW'(cols_c);
    assign load_wr = in_acc && (PW'(load_pos_reg) < cap_w);

    // Coordinate source: start cell on the seed step, stack top otherwise.
    assign start_off = (XR'(start_row_reg) >= XR'(rows_c)) ||
                       (XC'(start_col_reg) >= XC'(cols_c));
    assign src_r = (uw.op == grs_pkg::OP_START) ? RB'(start_row_reg) : stk_rdata[SW-1:CB];
    assign src_c = (uw.op == grs_pkg::OP_START) ? CB'(start_col_reg) : stk_rdata[CB-1:0];
    assign coord_match = (ER'(src_r) == ER'(end_row_reg)) && (EC'(src_c) == EC'(end_col_reg));
    assign hit = coord_match || ((uw.op == grs_pkg::OP_START) && start_off);

    // Neighbor of the current cell in the direction of this step.
    always_comb
    begin
        nb_in_grid = 1'b0;
        nb_addr_w  = LW'(lin_reg);
        nb_r_w     = cur_r_reg;
        nb_c_w     = cur_c_reg;
        unique case (uw.dir)
            grs_pkg::DIR_RIGHT:
            begin
                nb_in_grid = (CN'(cur_c_reg) + CN'(1)) < cols_c;
                nb_addr_w  = LW'(lin_reg) + LW'(1);
                nb_c_w     = cur_c_reg + CB'(1);
            end
            grs_pkg::DIR_DOWN:
            begin
                nb_in_grid = (RN'(cur_r_reg) + RN'(1)) < rows_c;
                nb_addr_w  = LW'(lin_reg) + LW'(cols_c);
                nb_r_w     = cur_r_reg + RB'(1);
            end
            grs_pkg::DIR_LEFT:
            begin
                nb_in_grid = (cur_c_reg != '0);
                nb_addr_w  = LW'(lin_reg) - LW'(1);
                nb_c_w     = cur_c_reg - CB'(1);
            end
            grs_pkg::DIR_UP:
            begin
                nb_in_grid = (cur_r_reg != '0);
                nb_addr_w  = LW'(lin_reg) - LW'(cols_c);
                nb_r_w     = cur_r_reg - RB'(1);
            end
        endcase
    end

    // Cells past the loaded count are not read and count as walls.
    assign nb_ok      = nb_in_grid && (nb_addr_w < load_pos_reg);
    assign stack_room = stack_cnt_reg < LW'(CELL_CAP);
    assign push       = (uw.op == grs_pkg::OP_NB_CHK) &&
                        cell_rdata[grs_pkg::OPEN_BIT] && !cell_rdata[grs_pkg::SEEN_BIT];

    // Jump condition of the current control word.
    always_comb
    begin
        unique case (uw.cond)
            grs_pkg::C_NONE:     jump = 1'b0;
            grs_pkg::C_ALWAYS:   jump = 1'b1;
            grs_pkg::C_LAST_IN:  jump = in_acc && s_tlast;
            grs_pkg::C_HIT:      jump = hit;
            grs_pkg::C_NB_SKIP:  jump = !nb_ok;
            grs_pkg::C_EMPTY:    jump = (stack_cnt_reg == '0);
            grs_pkg::C_OUT_FREE: jump = !out_valid_reg || m_tready;
            default:             jump = 1'b1;
        endcase
    end

    // Step counter.
    always_comb
    begin
        if (jump)
        begin
            pc_next = uw.target;
        end
        else if (uw.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + grs_pkg::grs_pc_t'(1);
        end
    end

    // Datapath controlled by the current control word.
    always_comb
    begin
        load_pos_next  = load_pos_reg;
        stack_cnt_next = stack_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        found_next     = found_reg;
        path_next      = path_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        lin_next       = lin_reg;
        nb_r_next      = nb_r_reg;
        nb_c_next      = nb_c_reg;
        nb_addr_next   = nb_addr_reg;

        cell_we    = 1'b0;
        cell_waddr = nb_addr_reg;
        cell_wdata = '1;
        cell_re    = 1'b0;
        cell_raddr = lin_reg;
        stk_we     = 1'b0;
        stk_waddr  = AW'(stack_cnt_reg);
        stk_wdata  = {nb_r_reg, nb_c_reg};
        stk_re     = 1'b0;
        stk_raddr  = AW'(stack_cnt_reg - LW'(1));

        unique case (uw.op)
            grs_pkg::OP_LOAD:
            begin
                cell_we    = load_wr;
                cell_waddr = AW'(load_pos_reg);
                cell_wdata = {1'b0, s_tdata[0]};
                if (load_wr)
                begin
                    load_pos_next = load_pos_reg + LW'(1);
                end
            end
            grs_pkg::OP_START, grs_pkg::OP_POP_TAKE:
            begin
                // Take the cell as current: linear address and end check.
                cur_r_next = src_r;
                cur_c_next = src_c;
                lin_next   = AW'(PW'(src_r) * PW'(cols_c) + PW'(src_c));
                found_next = coord_match && !((uw.op == grs_pkg::OP_START) && start_off);
                if (uw.op == grs_pkg::OP_START)
                begin
                    stack_cnt_next = '0;
                end
            end
            grs_pkg::OP_MARK_RD:
            begin
                cell_re = 1'b1;
            end
            grs_pkg::OP_MARK_WR:
            begin
                // The start cell counts as visited, its open bit unchanged.
                cell_we    = 1'b1;
                cell_waddr = lin_reg;
                cell_wdata = {1'b1, cell_rdata[grs_pkg::OPEN_BIT]};
            end
            grs_pkg::OP_POP:
            begin
                if (stack_cnt_reg != '0)
                begin
                    stk_re         = 1'b1;
                    stack_cnt_next = stack_cnt_reg - LW'(1);
                end
            end
            grs_pkg::OP_NB_RD:
            begin
                cell_re      = nb_ok;
                cell_raddr   = AW'(nb_addr_w);
                nb_addr_next = AW'(nb_addr_w);
                nb_r_next    = nb_r_w;
                nb_c_next    = nb_c_w;
            end
            grs_pkg::OP_NB_CHK:
            begin
                // Open and not yet seen: mark it, and push it while the stack has room.
                cell_we = push;
                stk_we  = push && stack_room;
                if (push && stack_room)
                begin
                    stack_cnt_next = stack_cnt_reg + LW'(1);
                end
            end
            grs_pkg::OP_DONE:
            begin
                if (jump)
                begin
                    out_valid_next = 1'b1;
                    path_next      = found_reg;
                    load_pos_next  = '0;
                    stack_cnt_next = '0;
                end
            end
            grs_pkg::OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= grs_pkg::PC_IDLE;
            load_pos_reg  <= '0;
            stack_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            load_pos_reg  <= load_pos_next;
            stack_cnt_reg <= stack_cnt_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= grs_pkg::GRID_DIM_RST;
            grid_cols_reg <= grs_pkg::GRID_DIM_RST;
            start_row_reg <= grs_pkg::COORD_RST;
            start_col_reg <= grs_pkg::COORD_RST;
            end_row_reg   <= grs_pkg::COORD_RST;
            end_col_reg   <= grs_pkg::COORD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                grs_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                grs_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                grs_pkg::CFG_START_ROW: start_row_reg <= cfg_data[grs_pkg::COORD_W-1:0];
                grs_pkg::CFG_START_COL: start_col_reg <= cfg_data[grs_pkg::COORD_W-1:0];
                grs_pkg::CFG_END_ROW:   end_row_reg   <= cfg_data[grs_pkg::COORD_W-1:0];
                grs_pkg::CFG_END_COL:   end_col_reg   <= cfg_data[grs_pkg::COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_r_reg   <= cur_r_next;
        cur_c_reg   <= cur_c_next;
        lin_reg     <= lin_next;
        nb_r_reg    <= nb_r_next;
        nb_c_reg    <= nb_c_next;
        nb_addr_reg <= nb_addr_next;
        path_reg    <= path_next;
    end

    // Cell store: open and visited bits by linear load position.
    grs_ram #(
        .WIDTH (grs_pkg::CELL_W),
        .DEPTH (CELL_CAP)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // Search stack of {row, col}.
    grs_ram #(
        .WIDTH (SW),
        .DEPTH (CELL_CAP)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule

[hdl/grs_checker.sv]
// Port-level checker for the grid reachability search core, bound to the top level.
module grs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [grs_pkg::TDATA_W-1:0]    m_tdata
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The last cell of a maze starts the search, which blocks further cells.
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("cell taken right after last cell");

    // A new result is posted only out of the search, never while loading.
    a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while loading");

    // Padding bits of the result stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[grs_pkg::TDATA_W-1:1] == '0))
        else $error("result padding not zero");

endmodule

bind grid_reachability_search_core grs_checker u_grs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb.sv]
// Self-checking testbench for the grid reachability search core.
`timescale 1ns / 1ps

module tb;

    localparam int     MAX_DIM             = 64;
    localparam int     CELL_CAP            = MAX_DIM * MAX_DIM;
    localparam int     RANDOM_CELLS        = 480;
    localparam int     MIN_RANDOM_SEARCHES = 40;
    localparam int     HOLD_OFF_CYCLES     = 80;
    localparam int     SETTLE_CYCLES       = 4;
    localparam int     DEEP_ROWS           = 4;
    localparam longint TIMEOUT_NS          = 10_000_000;

    // Highest register index with a meaning; anything above must be ignored.
    localparam logic [grs_pkg::CFG_IDX_W-1:0] CFG_LAST_REG = grs_pkg::CFG_END_COL;

    typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_mode_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [grs_pkg::TDATA_W-1:0]    s_tdata   = '0;    // [0] cell_open, [7:1] zero
    logic                           s_tlast   = 1'b0;  // last_cell
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [grs_pkg::TDATA_W-1:0]    m_tdata;           // [0] path_found, [7:1] zero
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [grs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [grs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers, the cell memory and the load count.
    logic [grs_pkg::DIM_W-1:0]   maze_rows = grs_pkg::GRID_DIM_RST;
    logic [grs_pkg::DIM_W-1:0]   maze_cols = grs_pkg::GRID_DIM_RST;
    logic [grs_pkg::COORD_W-1:0] src_row   = grs_pkg::COORD_RST;
    logic [grs_pkg::COORD_W-1:0] src_col   = grs_pkg::COORD_RST;
    logic [grs_pkg::COORD_W-1:0] dst_row   = grs_pkg::COORD_RST;
    logic [grs_pkg::COORD_W-1:0] dst_col   = grs_pkg::COORD_RST;
    bit                          floor_map [CELL_CAP];
    int unsigned                 cells_loaded = 0;

    // Expected path_found values, oldest first.
    bit pending_path_found [$];
    bit next_path_found;

    int n_errors     = 0;
    int n_cells_sent = 0;
    int n_searches   = 0;
    int n_reached    = 0;
    int burst_left   = 0;
    int rx_hold_len  = 0;

    grid_reachability_search_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic int unsigned dim_in_use(input logic [grs_pkg::DIM_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    // Depth-first walk from the start cell; neighbors pushed right, down, left, up.
    // Only cells loaded for this maze can be entered; the start is taken as is.
    function automatic bit dfs_reaches_goal();
        int unsigned       rows;
        int unsigned       cols;
        int unsigned       cur;
        int unsigned       r;
        int unsigned       c;
        int unsigned       nb;
        int                d;
        bit                ok;
        bit                seen [CELL_CAP];
        int unsigned       stack [$];
        grs_pkg::grs_dir_t dir;
        rows = dim_in_use(maze_rows);
        cols = dim_in_use(maze_cols);
        if (src_row >= rows || src_col >= cols)
            return 1'b0;
        cur = src_row * cols + src_col;
        seen[cur] = 1'b1;
        stack.push_back(cur);
        while (stack.size() != 0)
        begin
            cur = stack.pop_back();
            r = cur / cols;
            c = cur % cols;
            if (r == dst_row && c == dst_col)
                return 1'b1;
            for (d = 0; d < 4; d++)
            begin
                dir = grs_pkg::grs_dir_t'(d);
                ok  = 1'b0;
                nb  = 0;
                case (dir)
                    grs_pkg::DIR_RIGHT:
                    begin
                        ok = (c + 1 < cols);
                        nb = cur + 1;
                    end
                    grs_pkg::DIR_DOWN:
                    begin
                        ok = (r + 1 < rows);
                        nb = cur + cols;
                    end
                    grs_pkg::DIR_LEFT:
                    begin
                        ok = (c > 0);
                        nb = cur - 1;
                    end
                    default:
                    begin
                        ok = (r > 0);
                        nb = cur - cols;
                    end
                endcase
                if (ok && nb < cells_loaded && floor_map[nb] && !seen[nb])
                begin
                    seen[nb] = 1'b1;
                    stack.push_back(nb);
                end
            end
        end
        return 1'b0;
    endfunction

    // Surplus cells past rows * cols are dropped; last_cell still runs the search.
    function automatic void predict_cell(input bit open_bit, input bit last_bit);
        bit reached;
        n_cells_sent++;
        if (cells_loaded < dim_in_use(maze_rows) * dim_in_use(maze_cols))
        begin
            floor_map[cells_loaded] = open_bit;
            cells_loaded++;
        end
        if (last_bit)
        begin
            reached = dfs_reaches_goal();
            pending_path_found.push_back(reached);
            cells_loaded = 0;
            n_searches++;
            if (reached)
                n_reached++;
        end
    endfunction

    function automatic void predict_reg_write(input logic [grs_pkg::CFG_IDX_W-1:0] idx,
                                              input logic [grs_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            grs_pkg::CFG_GRID_ROWS: maze_rows = val[grs_pkg::DIM_W-1:0];
            grs_pkg::CFG_GRID_COLS: maze_cols = val[grs_pkg::DIM_W-1:0];
            grs_pkg::CFG_START_ROW: src_row   = val[grs_pkg::COORD_W-1:0];
            grs_pkg::CFG_START_COL: src_col   = val[grs_pkg::COORD_W-1:0];
            grs_pkg::CFG_END_ROW:   dst_row   = val[grs_pkg::COORD_W-1:0];
            grs_pkg::CFG_END_COL:   dst_col   = val[grs_pkg::COORD_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking: each m_ transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_path_found.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual tdata=%0h",
                         $time, m_tdata);
                n_errors++;
            end
            else
            begin
                next_path_found = pending_path_found.pop_front();
                if (m_tdata[0] !== next_path_found)
                begin
                    $display("%0t: path_found mismatch: expected %0b, actual %0b",
                             $time, next_path_found, m_tdata[0]);
                    n_errors++;
                end
                if (m_tdata[grs_pkg::TDATA_W-1:1] !== '0)
                begin
                    $display("%0t: tdata padding mismatch: expected 0, actual %0h",
                             $time, m_tdata[grs_pkg::TDATA_W-1:1]);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a counted hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        rx_mode_t mode;
        int       mode_left;
        mode      = RX_STEADY;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len != 0)
            begin
                // Long hold-off so the core fills up and stalls s_.
                m_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_len = 0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_STEADY: m_tready <= 1'b1;
                    RX_CHOPPY: m_tready <= ($urandom_range(0, 1) == 1);
                    default:   m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. All tasks start and end on a rising edge.
    // ------------------------------------------------------------------

    // One s_ transaction. Bursts of random length, random gaps between them;
    // tvalid stays high between back-to-back cells.
    task automatic send_cell(input bit open_bit, input bit last_bit);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(grs_pkg::TDATA_W-1){1'b0}}, open_bit};
        s_tlast  <= last_bit;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_cell(open_bit, last_bit);
    endtask

    // Cells taken from a bit pattern, lowest bit first; last_cell on the final one.
    task automatic send_cells(input bit [15:0] opens, input int n);
        int i;
        for (i = 0; i < n; i++)
            send_cell(opens[i], i == n - 1);
    endtask

    task automatic cells_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // One cfg_ transaction.
    task automatic write_reg(input int idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[grs_pkg::CFG_IDX_W-1:0];
        cfg_data  <= val[grs_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        predict_reg_write(idx[grs_pkg::CFG_IDX_W-1:0], val[grs_pkg::CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_maze_config(input int rows, input int cols,
                                   input int sr, input int sc, input int er, input int ec);
        write_reg(grs_pkg::CFG_GRID_ROWS, rows);
        write_reg(grs_pkg::CFG_GRID_COLS, cols);
        write_reg(grs_pkg::CFG_START_ROW, sr);
        write_reg(grs_pkg::CFG_START_COL, sc);
        write_reg(grs_pkg::CFG_END_ROW, er);
        write_reg(grs_pkg::CFG_END_COL, ec);
    endtask

    // Wait for every expected result, then let the core get back to loading.
    task automatic wait_drained();
        while (pending_path_found.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic finish_phase();
        cells_idle();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: 64x64, start and goal both at the origin, so a single
    // walled cell still counts as reached.
    task automatic test_reset_defaults();
        send_cell(1'b0, 1'b1);
        finish_phase();
    endtask

    // One-cell grids, zero sizes acting as one, oversize acting as 64,
    // goal off the grid and goal never loaded.
    task automatic test_degenerate_sizes();
        set_maze_config(1, 1, 0, 0, 0, 0);
        send_cells(16'h0000, 1);
        finish_phase();
        set_maze_config(0, 0, 0, 0, 0, 1);
        send_cells(16'h0001, 1);
        finish_phase();
        set_maze_config(127, 127, 0, 0, 63, 63);
        send_cells(16'h0001, 1);
        finish_phase();
    endtask

    task automatic test_start_off_grid();
        set_maze_config(2, 2, 2, 0, 0, 0);
        send_cells(16'h000F, 4);
        finish_phase();
        set_maze_config(64, 2, 63, 63, 0, 0);
        send_cells(16'h0001, 1);
        finish_phase();
    endtask

    // 1x3 corridor: plain run, walled start with surplus cells, missing cells.
    task automatic test_corridor();
        set_maze_config(1, 3, 0, 0, 0, 2);
        send_cells(16'h0007, 3);
        finish_phase();
        send_cells(16'h0006, 5);
        finish_phase();
        send_cells(16'h0003, 2);
        finish_phase();
    endtask

    // Start bottom right, goal top left: only left and up moves get there.
    task automatic test_climb();
        set_maze_config(2, 2, 1, 1, 0, 0);
        send_cells(16'h000F, 4);
        finish_phase();
    endtask

    // Columns change part way through a load; cells keep their linear slot.
    task automatic test_resize_mid_load();
        set_maze_config(2, 3, 0, 0, 1, 1);
        send_cells(16'h0003, 0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b0);
        cells_idle();
        write_reg(grs_pkg::CFG_GRID_COLS, 2);
        send_cell(1'b1, 1'b1);
        finish_phase();
    endtask

    // Writes to indexes with no register must leave the setup alone.
    task automatic test_unmapped_registers();
        int idx;
        set_maze_config(1, 2, 0, 0, 0, 1);
        for (idx = CFG_LAST_REG + 1; idx < (1 << grs_pkg::CFG_IDX_W); idx++)
            write_reg(idx, (1 << grs_pkg::CFG_DATA_W) - 1);
        send_cells(16'h0003, 2);
        finish_phase();
    endtask

    // Receiver holds off while tiny mazes keep coming: one result parks in
    // the core and s_tready has to drop.
    task automatic test_output_hold_off();
        int k;
        set_maze_config(1, 2, 0, 0, 0, 1);
        rx_hold_len = HOLD_OFF_CYCLES;
        for (k = 0; k < 5; k++)
        begin
            send_cell(1'b1, 1'b0);
            send_cell($urandom_range(0, 1), 1'b1);
        end
        finish_phase();
    endtask

    // Mostly small sizes, sometimes the extremes.
    function automatic int unsigned pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIM;
            3:       return $urandom_range(MAX_DIM + 1, (1 << grs_pkg::DIM_W) - 1);
            4, 5:    return $urandom_range(9, MAX_DIM);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Random mazes. Start and goal mostly fall inside the loaded cells; grids
    // of more than 64 cells get only a short partial load so the run stays short.
    task automatic test_random_mazes();
        int unsigned rows;
        int unsigned cols;
        int unsigned rows_c;
        int unsigned cols_c;
        int unsigned cap;
        int unsigned n;
        int unsigned loaded;
        int unsigned pct;
        int unsigned sel;
        int unsigned idx;
        int unsigned i;
        int unsigned sr;
        int unsigned sc;
        int unsigned er;
        int unsigned ec;
        int          cells_before;
        int          searches_before;
        bit          reuse;
        cells_before    = n_cells_sent;
        searches_before = n_searches;
        reuse           = 1'b0;
        n               = 1;
        while (n_cells_sent - cells_before < RANDOM_CELLS ||
               n_searches - searches_before < MIN_RANDOM_SEARCHES)
        begin
            if (!reuse)
            begin
                finish_phase();
                rows   = pick_dim();
                cols   = pick_dim();
                rows_c = dim_in_use(rows[grs_pkg::DIM_W-1:0]);
                cols_c = dim_in_use(cols[grs_pkg::DIM_W-1:0]);
                cap    = rows_c * cols_c;
                if (cap > MAX_DIM)
                    n = $urandom_range(1, 48);
                else
                begin
                    sel = $urandom_range(0, 7);
                    if (sel == 0)
                        n = $urandom_range(1, cap);
                    else if (sel == 1)
                        n = cap + $urandom_range(1, 3);
                    else
                        n = cap;
                end
                loaded = (n < cap) ? n : cap;

                sel = $urandom_range(0, 9);
                if (sel == 0 && rows_c < MAX_DIM)
                begin
                    sr = $urandom_range(rows_c, MAX_DIM - 1);
                    sc = $urandom_range(0, MAX_DIM - 1);
                end
                else if (sel == 0 && cols_c < MAX_DIM)
                begin
                    sr = $urandom_range(0, MAX_DIM - 1);
                    sc = $urandom_range(cols_c, MAX_DIM - 1);
                end
                else
                begin
                    idx = $urandom_range(0, loaded - 1);
                    sr  = idx / cols_c;
                    sc  = idx % cols_c;
                end

                sel = $urandom_range(0, 9);
                if (sel < 2)
                begin
                    er = $urandom_range(0, MAX_DIM - 1);
                    ec = $urandom_range(0, MAX_DIM - 1);
                end
                else if (sel == 2)
                begin
                    er = sr;
                    ec = sc;
                end
                else
                begin
                    idx = $urandom_range(0, loaded - 1);
                    er  = idx / cols_c;
                    ec  = idx % cols_c;
                end
                set_maze_config(rows, cols, sr, sc, er, ec);
            end
            pct = $urandom_range(40, 95);
            for (i = 0; i < n; i++)
                send_cell($urandom_range(0, 99) < pct, i == n - 1);
            // Sometimes the next maze follows at once, with no pause on s_.
            reuse = ($urandom_range(0, 2) == 0);
        end
        finish_phase();
    endtask

    // Oversized rows acting as 64, full-width rows, only the top rows loaded:
    // deep stack, and the rows below count as walls.
    task automatic test_full_grid();
        int i;
        set_maze_config(127, MAX_DIM, 0, 0, DEEP_ROWS - 1, MAX_DIM - 1);
        for (i = 0; i < DEEP_ROWS * MAX_DIM; i++)
            send_cell($urandom_range(0, 99) < 90, i == DEEP_ROWS * MAX_DIM - 1);
        finish_phase();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_degenerate_sizes();
        test_start_off_grid();
        test_corridor();
        test_climb();
        test_resize_mid_load();
        test_unmapped_registers();
        test_output_hold_off();
        test_random_mazes();
        test_full_grid();

        repeat (20) @(posedge clk);
        $display("Sent %0d cells in %0d mazes, goal reached in %0d, grids from 1x1 to 64x64.",
                 n_cells_sent, n_searches, n_reached);
        $display("Also hit: output hold-off, missing and surplus cells, mid-load resize.");
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d results still expected", $time,
                 pending_path_found.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/grs_pkg.sv
hdl/grs_ram.sv
hdl/grid_reachability_search_core.sv
hdl/grs_checker.sv
tb/tb.sv
